### hdl/t3si_pkg.sv
// Package for the 3D turtle interpreter: item types, action codes and the
// fixed-point helpers for the core and its output queue. No dependencies.
package t3si_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int OUTQ_DEPTH      = 4;

  localparam logic [3:0] ACT_MOVE    = 4'd0;
  localparam logic [3:0] ACT_YAW_P   = 4'd1;
  localparam logic [3:0] ACT_YAW_M   = 4'd2;
  localparam logic [3:0] ACT_PITCH_P = 4'd3;
  localparam logic [3:0] ACT_PITCH_M = 4'd4;
  localparam logic [3:0] ACT_ROLL_P  = 4'd5;
  localparam logic [3:0] ACT_ROLL_M  = 4'd6;
  localparam logic [3:0] ACT_TURN    = 4'd7;
  localparam logic [3:0] ACT_PUSH    = 4'd8;
  localparam logic [3:0] ACT_POP     = 4'd9;
  localparam logic [3:0] ACT_END     = 4'd10;

  localparam logic CFG_COS = 1'b0;
  localparam logic CFG_SIN = 1'b1;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    vec_t pos;
    vec_t hd;
    vec_t lf;
    vec_t up;
  } turtle_t;

  typedef struct packed {
    logic [3:0] action;
    logic       draw_line;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               joins_previous;
    logic               stack_fault;
    logic               last_of_run;
  } out_item_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // x*c + y*s, rounded to Q2.30 by floor of (+2^29) >> 30, saturated
  function automatic logic [31:0] rot(input logic signed [31:0] x,
                                      input logic signed [31:0] y,
                                      input logic signed [31:0] c,
                                      input logic signed [32:0] s);
    logic signed [65:0] acc;
    acc = 66'(x) * 66'(c) + 66'(y) * 66'(s) + 66'sd536870912;
    return sat32(acc >>> 30);
  endfunction

  // Q2.30 heading component to Q16.16 step, added to position
  function automatic logic [31:0] step(input logic signed [31:0] p,
                                       input logic signed [31:0] h);
    logic signed [65:0] d;
    d = (66'(h) + 66'sd8192) >>> 14;
    return sat32(66'(p) + d);
  endfunction

endpackage

### hdl/turtle_3d_symbol_interpreter_core.sv
// Top level of the 3D turtle symbol interpreter: turtle state, rotations,
// bracket stack memory and result queue. Depends on t3si_pkg and t3si_outq.
//
// One symbol is taken per cycle; its whole effect (a move, a rotation of two
// vectors by 12 parallel 32x33 multiplies, or a stack access) is computed in
// that cycle and its zero, one or two result items go into a four-entry
// queue. in_stall rises while the queue holds more than two items, so a
// symbol that yields two results needs the consumer to keep up. Pops read a
// cached top entry, with the entry below prefetched from the stack RAM.
module turtle_3d_symbol_interpreter_core
  import t3si_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [31:0] cos_r, sin_r;
  turtle_t            st_r, st_nxt;
  vec_t               run_end_r, run_end_nxt;
  logic               run_r, run_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  turtle_t            tos_r, tos_nxt;
  turtle_t            stk [STACK_DEPTH];
  turtle_t            below_r;
  logic [AW-1:0]      rd_addr;
  logic               push_we;

  logic               acc, room2;
  logic [1:0]         wr_n;
  out_item_t          d0, d1, res;
  logic               has_res, fault;
  logic signed [32:0] s_eff;
  vec_t               va, vb, na, nb, mv;
  logic [3:0]         act;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room2;
  assign acc       = in_valid && !in_stall;
  assign act       = in_data.action;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= ONE_Q30;
      sin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COS: cos_r <= cfg_data;
        default: sin_r <= cfg_data;
      endcase
    end
  end

  // rotation operand pair and sign of the sine
  always_comb begin
    s_eff = 33'(sin_r);
    if (act == ACT_YAW_M || act == ACT_PITCH_M || act == ACT_ROLL_M) s_eff = -33'(sin_r);
    va = st_r.hd;
    vb = st_r.lf;
    if (act == ACT_PITCH_P || act == ACT_PITCH_M) vb = st_r.up;
    if (act == ACT_ROLL_P || act == ACT_ROLL_M) va = st_r.up;
    for (int i = 0; i < 3; i++) begin
      na[i] = rot(va[i], vb[i], cos_r, s_eff);
      nb[i] = rot(vb[i], va[i], cos_r, -s_eff);
      mv[i] = step(st_r.pos[i], st_r.hd[i]);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    run_end_nxt = run_end_r;
    run_nxt     = run_r;
    cnt_nxt     = cnt_r;
    tos_nxt     = tos_r;
    push_we     = 1'b0;
    has_res     = 1'b0;
    fault       = 1'b0;
    res         = '0;
    d0          = '0;
    d1          = '0;
    wr_n        = 2'd0;
    if (acc && act <= ACT_END) begin
      if (act == ACT_MOVE && in_data.draw_line) begin
        st_nxt.pos  = mv;
        run_end_nxt = mv;
        run_nxt     = 1'b1;
      end else begin
        run_nxt = 1'b0;
        unique case (act) inside
          ACT_MOVE: begin
            st_nxt.pos = mv;
            has_res    = 1'b1;
          end
          ACT_YAW_P, ACT_YAW_M: begin
            st_nxt.hd = na;
            st_nxt.lf = nb;
          end
          ACT_PITCH_P, ACT_PITCH_M: begin
            st_nxt.hd = na;
            st_nxt.up = nb;
          end
          ACT_ROLL_P, ACT_ROLL_M: begin
            st_nxt.up = na;
            st_nxt.lf = nb;
          end
          ACT_TURN: begin
            for (int i = 0; i < 3; i++) begin
              st_nxt.hd[i] = sat32(-66'($signed(st_r.hd[i])));
              st_nxt.lf[i] = sat32(-66'($signed(st_r.lf[i])));
            end
          end
          ACT_PUSH: begin
            if (cnt_r >= CW'(STACK_DEPTH)) begin
              has_res = 1'b1;
              fault   = 1'b1;
            end else begin
              push_we = 1'b1;
              tos_nxt = st_r;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          ACT_POP: begin
            has_res = 1'b1;
            if (cnt_r == '0) begin
              fault = 1'b1;
            end else begin
              st_nxt  = tos_r;
              tos_nxt = below_r;
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          default: ;
        endcase
        res.point_x        = st_nxt.pos[0];
        res.point_y        = st_nxt.pos[1];
        res.point_z        = st_nxt.pos[2];
        res.stack_fault    = fault;
        res.last_of_run    = 1'b1;
        if (run_r) begin
          d0.point_x        = run_end_r[0];
          d0.point_y        = run_end_r[1];
          d0.point_z        = run_end_r[2];
          d0.joins_previous = 1'b1;
          d0.last_of_run    = !has_res;
          d1   = res;
          wr_n = has_res ? 2'd2 : 2'd1;
        end else begin
          d0   = res;
          wr_n = has_res ? 2'd1 : 2'd0;
        end
      end
    end
  end

  // prefetch the entry below the new top; never collides with the push slot
  assign rd_addr = AW'(cnt_nxt - CW'(2));

  always_ff @(posedge clk) begin
    if (push_we) stk[AW'(cnt_r)] <= st_r;
    below_r <= stk[rd_addr];
    tos_r   <= tos_nxt;
    run_end_r <= run_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pos <= '0;
      st_r.hd  <= {32'd0, 32'd0, ONE_Q30};
      st_r.lf  <= {32'd0, ONE_Q30, 32'd0};
      st_r.up  <= {ONE_Q30, 32'd0, 32'd0};
      run_r    <= 1'b0;
      cnt_r    <= '0;
    end else begin
      st_r  <= st_nxt;
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  t3si_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_n      (wr_n),
    .wr_d0     (d0),
    .wr_d1     (d1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count past depth");
  a_draw_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && act == ACT_MOVE && in_data.draw_line) |-> (wr_n == 2'd0 && run_nxt))
    else $error("drawing move produced a result");
  a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && act == ACT_POP && cnt_r == '0) |=> (cnt_r == '0))
    else $error("pop on empty stack changed count");
`endif

endmodule

### hdl/t3si_outq.sv
// Small result queue for the turtle interpreter: takes up to two items per
// cycle, hands out one while out_stall is low. Depends on t3si_pkg.
module t3si_outq
  import t3si_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] wr_n,
  input  out_item_t wr_d0,
  input  out_item_t wr_d1,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(OUTQ_DEPTH);

  out_item_t          mem [OUTQ_DEPTH];
  logic [AW-1:0]      head_r, tail_r;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic               rd;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[head_r];
  assign rd        = out_valid && !out_stall;
  assign room2     = (cnt_r <= (AW+1)'(OUTQ_DEPTH - 2));
  assign cnt_nxt   = cnt_r + (AW+1)'(wr_n) - (AW+1)'(rd);

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) mem[tail_r] <= wr_d0;
    if (wr_n == 2'd2) mem[tail_r + AW'(1)] <= wr_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + AW'(wr_n);
      if (rd) head_r <= head_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(OUTQ_DEPTH)) else $error("result queue overflow");
  a_two_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_n == 2'd2) |-> (cnt_r <= (AW+1)'(OUTQ_DEPTH - 2)))
    else $error("double write without room");
`endif

endmodule

### verif/tb_turtle_3d_symbol_interpreter_core.sv
// Testbench for turtle_3d_symbol_interpreter_core: random and directed symbol
// streams vs an in-bench turtle predictor. Depends on t3si_pkg and the core.
module tb_turtle_3d_symbol_interpreter_core;
  import t3si_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;

  // ---------------- point scoreboard ----------------
  class point_board;
    logic signed [31:0] cos_a, sin_a;
    logic signed [31:0] pos[3], hd[3], lf[3], up[3], run_end[3];
    bit run_pending;
    logic signed [31:0] stk[DEPTH][12];
    int depth_used;
    out_item_t pending_pts[$];
    int errors;

    function new();
      int i;
      for (i = 0; i < 3; i++) begin
        pos[i] = 0; hd[i] = 0; lf[i] = 0; up[i] = 0; run_end[i] = 0;
      end
      hd[0] = ONE_Q30; lf[1] = ONE_Q30; up[2] = ONE_Q30;
      run_pending = 0; depth_used = 0; cos_a = ONE_Q30; sin_a = 0; errors = 0;
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function longint fl(longint v, int sh);
      return v >>> sh;
    endfunction

    function void turn(ref logic signed [31:0] a[3], ref logic signed [31:0] b[3],
                       input longint c, input longint s);
      int i;
      longint x, y;
      for (i = 0; i < 3; i++) begin
        x = a[i]; y = b[i];
        a[i] = clip(fl(x * c + y * s + (64'sd1 << 29), 30));
        b[i] = clip(fl(y * c - x * s + (64'sd1 << 29), 30));
      end
    endfunction

    function void push_pt(logic signed [31:0] p[3], bit j, bit f);
      out_item_t r;
      r.point_x = p[0]; r.point_y = p[1]; r.point_z = p[2];
      r.joins_previous = j; r.stack_fault = f; r.last_of_run = 0;
      pending_pts = {pending_pts, r};
    endfunction

    function void note_symbol(in_item_t it);
      int i, n0;
      longint c, s;
      out_item_t r;
      c = cos_a; s = sin_a;
      n0 = pending_pts.size();
      if (it.action > ACT_END) return;
      if (it.action == ACT_MOVE && it.draw_line) begin
        for (i = 0; i < 3; i++) begin
          pos[i] = clip(longint'(pos[i]) + fl(longint'(hd[i]) + 8192, 14));
          run_end[i] = pos[i];
        end
        run_pending = 1;
        return;
      end
      if (run_pending) begin
        push_pt(run_end, 1, 0);
        run_pending = 0;
      end
      case (it.action)
        ACT_MOVE: begin
          for (i = 0; i < 3; i++)
            pos[i] = clip(longint'(pos[i]) + fl(longint'(hd[i]) + 8192, 14));
          push_pt(pos, 0, 0);
        end
        ACT_YAW_P: turn(hd, lf, c, s);
        ACT_YAW_M: turn(hd, lf, c, -s);
        ACT_PITCH_P: turn(hd, up, c, s);
        ACT_PITCH_M: turn(hd, up, c, -s);
        ACT_ROLL_P: turn(up, lf, c, s);
        ACT_ROLL_M: turn(up, lf, c, -s);
        ACT_TURN: begin
          for (i = 0; i < 3; i++) begin
            hd[i] = clip(-longint'(hd[i]));
            lf[i] = clip(-longint'(lf[i]));
          end
        end
        ACT_PUSH: begin
          if (depth_used >= DEPTH) push_pt(pos, 0, 1);
          else begin
            for (i = 0; i < 3; i++) begin
              stk[depth_used][i] = pos[i]; stk[depth_used][3+i] = hd[i];
              stk[depth_used][6+i] = lf[i]; stk[depth_used][9+i] = up[i];
            end
            depth_used++;
          end
        end
        ACT_POP: begin
          if (depth_used == 0) push_pt(pos, 0, 1);
          else begin
            depth_used--;
            for (i = 0; i < 3; i++) begin
              pos[i] = stk[depth_used][i]; hd[i] = stk[depth_used][3+i];
              lf[i] = stk[depth_used][6+i]; up[i] = stk[depth_used][9+i];
            end
            push_pt(pos, 0, 0);
          end
        end
        default: ;
      endcase
      if (pending_pts.size() > n0) begin
        r = pending_pts[pending_pts.size() - 1];
        r.last_of_run = 1;
        pending_pts[pending_pts.size() - 1] = r;
      end
    endfunction

    task check_point(out_item_t got);
      out_item_t e;
      if (pending_pts.size() == 0) begin
        report("unexpected point");
        return;
      end
      e = pending_pts.pop_front();
      if (got.point_x !== e.point_x) report("point_x");
      if (got.point_y !== e.point_y) report("point_y");
      if (got.point_z !== e.point_z) report("point_z");
      if (got.joins_previous !== e.joins_previous) report("joins_previous");
      if (got.stack_fault !== e.stack_fault) report("stack_fault");
      if (got.last_of_run !== e.last_of_run) report("last_of_run");
    endtask

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s at %0t", what, $time);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0, cfg_index = 0;
  logic in_stall, out_valid, cfg_ready;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;
  point_board board = new();

  turtle_3d_symbol_interpreter_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data);

  always #5 clk = ~clk;

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_point(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays high after an accept; the next item or drain() decides
  task automatic send_symbol(logic [3:0] act, logic drw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{action: act, draw_line: drw};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_symbol('{action: act, draw_line: drw});
  endtask

  task automatic write_angle(logic [31:0] cval, logic [31:0] sval);
    cfg_valid <= 1; cfg_index <= CFG_COS; cfg_data <= cval;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.cos_a = cval;
    cfg_index <= CFG_SIN; cfg_data <= sval;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.sin_a = sval;
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic random_symbols(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) send_symbol(ACT_MOVE, 1'($urandom_range(1)));
      else if (r < 70)
        send_symbol(4'($urandom_range(ACT_YAW_P, ACT_TURN)), 1'($urandom_range(1)));
      else if (r < 82) send_symbol(ACT_PUSH, 1'($urandom_range(1)));
      else if (r < 94) send_symbol(ACT_POP, 1'($urandom_range(1)));
      else if (r < 97) send_symbol(ACT_END, 1'($urandom_range(1)));
      else send_symbol(4'($urandom_range(11, 15)), 1'($urandom_range(1)));
    end
  endtask

  // angle settings: 0 deg, 90 deg, -90 deg, 180 deg, 30 deg, 45 deg, random
  logic [31:0] cos_tab[7] = '{32'h40000000, 0, 0, 32'hc0000000, 32'h376cf5d1,
                              32'h2d413ccd, 0};
  logic [31:0] sin_tab[7] = '{0, 32'h40000000, 32'hc0000000, 0, 32'h20000000,
                              32'h2d413ccd, 0};

  initial begin
    int ph, k;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: every action, end flush, faults, stack full
    send_symbol(ACT_POP, 1'b0);
    send_symbol(ACT_MOVE, 1'b1); send_symbol(ACT_MOVE, 1'b1); send_symbol(ACT_END, 1'b0);
    send_symbol(ACT_MOVE, 1'b0); send_symbol(ACT_MOVE, 1'b1); send_symbol(ACT_PUSH, 1'b1);
    for (k = 1; k <= 7; k++) send_symbol(4'(k), 1'b1);
    send_symbol(ACT_MOVE, 1'b1); send_symbol(ACT_POP, 1'b1);
    send_symbol(4'd15, 1'b1); send_symbol(4'd11, 1'b0); send_symbol(ACT_END, 1'b1);
    drain();
    write_angle(32'hc0000000, 32'hc0000000);
    send_symbol(ACT_YAW_P, 1'b0); send_symbol(ACT_TURN, 1'b0); send_symbol(ACT_MOVE, 1'b0);
    for (k = 0; k < DEPTH + 2; k++) send_symbol(ACT_PUSH, 1'b0);
    for (k = 0; k < DEPTH + 2; k++) send_symbol(ACT_POP, 1'b0);
    drain();
    for (ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        cos_tab[6] = 32'($urandom_range(0, 32'h80000000) - 32'h40000000);
        sin_tab[6] = 32'($urandom_range(0, 32'h80000000) - 32'h40000000);
      end
      write_angle(cos_tab[ph], sin_tab[ph]);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 47 : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 47 : 0;
      if (ph % 4 == 3) begin send_idle_pct = 8; recv_stall_pct = 8; end
      if (ph == 2) hold_cycles = 300;
      random_symbols(130);
      drain();
    end
    // long drawing runs
    write_angle(32'h40000000, 32'h0);
    send_idle_pct = 0; recv_stall_pct = 0;
    for (k = 0; k < 4; k++) begin
      repeat (50) send_symbol(ACT_MOVE, 1'b1);
      send_symbol(ACT_MOVE, 1'b0);
      send_symbol(ACT_PITCH_P, 1'b0);
      send_symbol(ACT_TURN, 1'b0);
    end
    drain();
    if (board.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
hdl/t3si_pkg.sv
hdl/t3si_outq.sv
hdl/turtle_3d_symbol_interpreter_core.sv
verif/tb_turtle_3d_symbol_interpreter_core.sv
